### sv/rar_pkg.sv
// shared types and constants for the region address remapper
// no dependencies; used by rar_table, rar_exec and region_address_remapper_core
package rar_pkg;

	localparam int ADDR_W     = 48;
	localparam int ID_W       = 4;
	localparam int OP_W       = 2;
	localparam int ST_W       = 3;
	localparam int IN_DATA_W  = 152;   // id + base + upper + lookup, padded to bytes
	localparam int OUT_DATA_W = 48;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT    = 2'd0,
		OP_SET       = 2'd1,
		OP_TRANSLATE = 2'd2,
		OP_NONE      = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK           = 3'd0,
		ST_UNMAPPED     = 3'd1,
		ST_UNTRANSLATED = 3'd2,
		ST_DUPLICATE    = 3'd3,
		ST_UNKNOWN      = 3'd4,
		ST_MISMATCH     = 3'd5
	} status_t;

	// table update produced by the execute logic
	typedef struct packed {
		logic              ins;
		logic              set;
		logic [ID_W-1:0]   slot;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] upper;
		logic [ADDR_W-1:0] size;
		logic [ADDR_W-1:0] offset;
	} wr_cmd_t;

endpackage

### sv/rar_table.sv
// region table: valid flags, original bounds, region size and translation offset
// depends on rar_pkg
module rar_table #(
	parameter int NUM_REGIONS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rar_pkg::wr_cmd_t                wr,
	output logic [NUM_REGIONS-1:0]          region_valid,
	output logic [NUM_REGIONS-1:0]          translation_valid,
	output logic [rar_pkg::ADDR_W-1:0]      base [NUM_REGIONS],
	output logic [rar_pkg::ADDR_W-1:0]      upper [NUM_REGIONS],
	output logic [rar_pkg::ADDR_W-1:0]      size [NUM_REGIONS],
	output logic [rar_pkg::ADDR_W-1:0]      offset [NUM_REGIONS]
);

	logic [NUM_REGIONS-1:0]     rv_q;
	logic [NUM_REGIONS-1:0]     tv_q;
	logic [rar_pkg::ADDR_W-1:0] base_q [NUM_REGIONS];
	logic [rar_pkg::ADDR_W-1:0] upper_q [NUM_REGIONS];
	logic [rar_pkg::ADDR_W-1:0] size_q [NUM_REGIONS];
	logic [rar_pkg::ADDR_W-1:0] offset_q [NUM_REGIONS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= '0;
			tv_q <= '0;
		end else begin
			for (int i = 0; i < NUM_REGIONS; i++) begin
				if (wr.ins && int'(wr.slot) == i) begin
					rv_q[i] <= 1'b1;
					tv_q[i] <= 1'b0;
				end else if (wr.set && int'(wr.slot) == i) begin
					tv_q[i] <= 1'b1;
				end
			end
		end
	end

	// payload entries, no reset
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_REGIONS; i++) begin
			if (wr.ins && int'(wr.slot) == i) begin
				base_q[i]  <= wr.base;
				upper_q[i] <= wr.upper;
				size_q[i]  <= wr.size;
			end
			if (wr.set && int'(wr.slot) == i) begin
				offset_q[i] <= wr.offset;
			end
		end
	end

	assign region_valid      = rv_q;
	assign translation_valid = tv_q;
	assign base              = base_q;
	assign upper             = upper_q;
	assign size              = size_q;
	assign offset            = offset_q;

endmodule

### sv/rar_exec.sv
// execute logic: duplicate check, size check and parallel region lookup
// depends on rar_pkg; reads the contents of rar_table
module rar_exec #(
	parameter int NUM_REGIONS = 16
) (
	input  logic                            en,
	input  rar_pkg::op_t                    opcode,
	input  logic [rar_pkg::ID_W-1:0]        region_id,
	input  logic [rar_pkg::ADDR_W-1:0]      base_address,
	input  logic [rar_pkg::ADDR_W-1:0]      upper_bound,
	input  logic [rar_pkg::ADDR_W-1:0]      lookup_address,
	input  logic [NUM_REGIONS-1:0]          region_valid,
	input  logic [NUM_REGIONS-1:0]          translation_valid,
	input  logic [rar_pkg::ADDR_W-1:0]      base [NUM_REGIONS],
	input  logic [rar_pkg::ADDR_W-1:0]      upper [NUM_REGIONS],
	input  logic [rar_pkg::ADDR_W-1:0]      size [NUM_REGIONS],
	input  logic [rar_pkg::ADDR_W-1:0]      offset [NUM_REGIONS],
	output rar_pkg::wr_cmd_t                wr,
	output logic [rar_pkg::ADDR_W-1:0]      result_address,
	output rar_pkg::status_t                status
);

	logic                       slot_ok;
	logic                       slot_rv;
	logic [rar_pkg::ADDR_W-1:0] slot_base;
	logic [rar_pkg::ADDR_W-1:0] slot_size;
	logic                       dup;
	logic [rar_pkg::ADDR_W-1:0] span;
	logic [NUM_REGIONS-1:0]     cand;
	logic [NUM_REGIONS-1:0]     pick;
	logic [rar_pkg::ADDR_W-1:0] sel_upper;
	logic [rar_pkg::ADDR_W-1:0] sel_off;
	logic                       sel_tv;
	logic                       found;
	logic                       do_ins;
	logic                       do_set;

	// slot addressed by insert / set
	always_comb begin
		slot_ok   = int'(region_id) < NUM_REGIONS;
		slot_rv   = 1'b0;
		slot_base = '0;
		slot_size = '0;
		dup       = 1'b0;
		for (int i = 0; i < NUM_REGIONS; i++) begin
			if (int'(region_id) == i) begin
				slot_rv   = region_valid[i];
				slot_base = base[i];
				slot_size = size[i];
			end
			if (region_valid[i] && base[i] == base_address) begin
				dup = 1'b1;
			end
		end
	end

	assign span = upper_bound - base_address;

	// candidates at or below the address; valid bases are unique, so the
	// greatest candidate is the one no other candidate beats
	always_comb begin
		for (int i = 0; i < NUM_REGIONS; i++) begin
			cand[i] = region_valid[i] && (base[i] <= lookup_address);
		end
	end

	always_comb begin
		logic beaten;
		for (int i = 0; i < NUM_REGIONS; i++) begin
			beaten = 1'b0;
			for (int j = 0; j < NUM_REGIONS; j++) begin
				if (cand[j] && base[j] > base[i]) begin
					beaten = 1'b1;
				end
			end
			pick[i] = cand[i] && !beaten;
		end
	end

	// one-hot select of the chosen entry
	always_comb begin
		sel_upper = '0;
		sel_off   = '0;
		sel_tv    = 1'b0;
		for (int i = 0; i < NUM_REGIONS; i++) begin
			sel_upper = sel_upper | ({rar_pkg::ADDR_W{pick[i]}} & upper[i]);
			sel_off   = sel_off | ({rar_pkg::ADDR_W{pick[i]}} & offset[i]);
			sel_tv    = sel_tv | (pick[i] & translation_valid[i]);
		end
	end

	assign found = |cand;

	always_comb begin
		do_ins         = 1'b0;
		do_set         = 1'b0;
		result_address = '0;
		status         = rar_pkg::ST_OK;
		case (opcode)
			rar_pkg::OP_INSERT: begin
				if (!slot_ok) begin
					status = rar_pkg::ST_UNKNOWN;
				end else if (dup) begin
					status = rar_pkg::ST_DUPLICATE;
				end else begin
					do_ins = 1'b1;
				end
			end
			rar_pkg::OP_SET: begin
				if (!slot_ok || !slot_rv) begin
					status = rar_pkg::ST_UNKNOWN;
				end else if (span != slot_size) begin
					status = rar_pkg::ST_MISMATCH;
				end else begin
					do_set = 1'b1;
				end
			end
			rar_pkg::OP_TRANSLATE: begin
				result_address = lookup_address;
				if (!found || lookup_address > sel_upper) begin
					status = rar_pkg::ST_UNMAPPED;
				end else if (!sel_tv) begin
					status = rar_pkg::ST_UNTRANSLATED;
				end else begin
					result_address = lookup_address + sel_off;
				end
			end
			default: begin
				status = rar_pkg::ST_OK;
			end
		endcase
	end

	always_comb begin
		wr.ins    = en && do_ins;
		wr.set    = en && do_set;
		wr.slot   = region_id;
		wr.base   = base_address;
		wr.upper  = upper_bound;
		wr.size   = span;
		wr.offset = base_address - slot_base;   // translated start minus original base
	end

endmodule

### sv/region_address_remapper_core.sv
// region address remapper top level: input register, execute logic, result register
// depends on rar_pkg, rar_table and rar_exec
//
// Region address remapper. Each item carries an operation in s_tuser: insert a
// region (base and inclusive upper bound) into a numbered slot, set the
// translated base of a slot, or translate an address. A translation picks the
// valid region with the greatest base at or below the address and rebases the
// address into that region's translated range; an address past the region's
// upper bound, or with no region below it, passes through with status
// unmapped, and a region without a translation passes it through with status
// untranslated. Inserting a base already present is refused (duplicate base);
// a set whose span differs from the region's span is refused (size mismatch);
// an empty or out-of-range slot gives unknown region. Every item yields exactly
// one result. Throughput is one item per clock while the output is not stalled;
// each item passes through the input register and then the result register. The
// cycle time is set by the parallel base comparators across all NUM_REGIONS slots
// that pick the matching region, followed by one bound compare and one add. The
// result of an item sees every table update made by the items before it.
module region_address_remapper_core #(
	parameter int NUM_REGIONS = 16   // table slots, 1 to 256; slot ids above 15 are unreachable
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input items
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [rar_pkg::IN_DATA_W-1:0]  s_tdata,   // region_id, base_address, upper_bound, lookup_address
	input  logic [rar_pkg::OP_W-1:0]           s_tuser,   // opcode
	// result items
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [rar_pkg::OUT_DATA_W-1:0]     m_tdata,   // result_address
	output logic [rar_pkg::ST_W-1:0]           m_tuser    // status
);

	localparam int AW = rar_pkg::ADDR_W;
	localparam int IW = rar_pkg::ID_W;

	// input register stage
	logic                 valid_s1;
	rar_pkg::op_t         opcode_s1;
	logic [IW-1:0]        region_id_s1;
	logic [AW-1:0]        base_s1;
	logic [AW-1:0]        upper_s1;
	logic [AW-1:0]        lookup_s1;

	// result register stage
	logic                 valid_s2;
	logic [AW-1:0]        result_s2;
	rar_pkg::status_t     status_s2;

	logic                 advance;   // s1 item moves into the result register
	logic                 take_in;

	// table contents
	logic [NUM_REGIONS-1:0] region_valid;
	logic [NUM_REGIONS-1:0] translation_valid;
	logic [AW-1:0]          tbl_base [NUM_REGIONS];
	logic [AW-1:0]          tbl_upper [NUM_REGIONS];
	logic [AW-1:0]          tbl_size [NUM_REGIONS];
	logic [AW-1:0]          tbl_offset [NUM_REGIONS];

	rar_pkg::wr_cmd_t       wr;
	logic [AW-1:0]          exec_result;
	rar_pkg::status_t       exec_status;

	// result register frees up when empty or being taken this cycle
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign take_in  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload of the input stage, no reset
	always_ff @(posedge clk) begin
		if (take_in) begin
			opcode_s1    <= rar_pkg::op_t'(s_tuser);
			region_id_s1 <= s_tdata[IW-1:0];
			base_s1      <= s_tdata[IW +: AW];
			upper_s1     <= s_tdata[IW+AW +: AW];
			lookup_s1    <= s_tdata[IW+2*AW +: AW];
		end
	end

	rar_table #(
		.NUM_REGIONS (NUM_REGIONS)
	) u_table (
		.clk               (clk),
		.arst_n            (arst_n),
		.wr                (wr),
		.region_valid      (region_valid),
		.translation_valid (translation_valid),
		.base              (tbl_base),
		.upper             (tbl_upper),
		.size              (tbl_size),
		.offset            (tbl_offset)
	);

	// table writes happen only as the item leaves s1, so the next item sees them
	rar_exec #(
		.NUM_REGIONS (NUM_REGIONS)
	) u_exec (
		.en                (advance),
		.opcode            (opcode_s1),
		.region_id         (region_id_s1),
		.base_address      (base_s1),
		.upper_bound       (upper_s1),
		.lookup_address    (lookup_s1),
		.region_valid      (region_valid),
		.translation_valid (translation_valid),
		.base              (tbl_base),
		.upper             (tbl_upper),
		.size              (tbl_size),
		.offset            (tbl_offset),
		.wr                (wr),
		.result_address    (exec_result),
		.status            (exec_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= exec_result;
			status_s2 <= exec_status;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;
	assign m_tuser  = status_s2;

`ifndef NO_ASSERTIONS
	// an item leaving s1 always lands in the result register
	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("item lost between s1 and result register");

	// input stalls only when both stages are full and the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("input stalled without cause");

	// table updates only while an item advances, and never both kinds at once
	a_wr_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.ins || wr.set) |-> (advance && !(wr.ins && wr.set)))
		else $error("table written outside an advancing item");

	// refusals report a zero address, as do table operations; only refusals are checked
	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (status_s2 == rar_pkg::ST_DUPLICATE ||
			status_s2 == rar_pkg::ST_UNKNOWN || status_s2 == rar_pkg::ST_MISMATCH))
		|-> (result_s2 == '0))
		else $error("nonzero address on refused operation");
`endif

endmodule

### verif/region_address_remapper_core_tb.sv
// testbench for region_address_remapper_core: directed and random insert, set and translate items
// depends on rar_pkg and the remapper RTL; holds its own table predictor and checks every result
module region_address_remapper_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ADDR_W       = rar_pkg::ADDR_W;
	localparam int ID_W         = rar_pkg::ID_W;
	localparam int OP_W         = rar_pkg::OP_W;
	localparam int ST_W         = rar_pkg::ST_W;
	localparam int IN_DATA_W    = rar_pkg::IN_DATA_W;
	localparam int OUT_DATA_W   = rar_pkg::OUT_DATA_W;
	localparam int NUM_SLOTS    = 16;
	localparam int RANDOM_ITEMS = 400;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		rar_pkg::status_t  status;
	} remap_result_t;

	// shadow copy of the region table; predicts one result per accepted item
	class remap_scoreboard;
		bit                region_used [NUM_SLOTS];
		bit                mapped      [NUM_SLOTS];
		logic [ADDR_W-1:0] region_lo   [NUM_SLOTS];
		logic [ADDR_W-1:0] region_hi   [NUM_SLOTS];
		logic [ADDR_W-1:0] target_lo   [NUM_SLOTS];
		remap_result_t     pending_results[$];
		int                errors;
		int                checked;
		int                hits;

		function void note_request(rar_pkg::op_t op, logic [ID_W-1:0] id,
				logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] upper, logic [ADDR_W-1:0] lookup);
			remap_result_t r;
			bit            found;
			int            pick;
			r.addr   = '0;
			r.status = rar_pkg::ST_OK;
			found    = 1'b0;
			pick     = 0;
			case (op)
				rar_pkg::OP_INSERT: begin
					for (int i = 0; i < NUM_SLOTS; i++)
						if (region_used[i] && region_lo[i] == base)
							found = 1'b1;
					if (found) begin
						r.status = rar_pkg::ST_DUPLICATE;
					end else begin
						region_used[id] = 1'b1;
						mapped[id]      = 1'b0;
						region_lo[id]   = base;
						region_hi[id]   = upper;
					end
				end
				rar_pkg::OP_SET: begin
					if (!region_used[id])
						r.status = rar_pkg::ST_UNKNOWN;
					else if (ADDR_W'(upper - base) != ADDR_W'(region_hi[id] - region_lo[id]))
						r.status = rar_pkg::ST_MISMATCH;
					else begin
						target_lo[id] = base;
						mapped[id]    = 1'b1;
					end
				end
				rar_pkg::OP_TRANSLATE: begin
					r.addr = lookup;
					for (int i = 0; i < NUM_SLOTS; i++)
						if (region_used[i] && region_lo[i] <= lookup &&
								(!found || region_lo[i] > region_lo[pick])) begin
							pick  = i;
							found = 1'b1;
						end
					if (!found || lookup > region_hi[pick])
						r.status = rar_pkg::ST_UNMAPPED;
					else if (!mapped[pick])
						r.status = rar_pkg::ST_UNTRANSLATED;
					else
						r.addr = ADDR_W'(lookup - region_lo[pick] + target_lo[pick]);
				end
				default: ;
			endcase
			pending_results.push_back(r);
		endfunction

		function void check_response(logic [ADDR_W-1:0] addr, logic [ST_W-1:0] status);
			remap_result_t exp_r;
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: result_address %h status %0d", addr, status);
				errors++;
				return;
			end
			exp_r = pending_results.pop_front();
			checked++;
			if (exp_r.status == rar_pkg::ST_OK && addr != '0)
				hits++;
			if (addr !== exp_r.addr) begin
				$error("result_address: expected %h, actual %h", exp_r.addr, addr);
				errors++;
			end
			if (status !== exp_r.status) begin
				$error("status: expected %0d, actual %0d", exp_r.status, status);
				errors++;
			end
		endfunction
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;   // region_id, base_address, upper_bound, lookup_address
	logic [OP_W-1:0]       s_tuser  = '0;   // opcode
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // result_address
	logic [ST_W-1:0]       m_tuser;         // status

	remap_scoreboard sb = new();
	int sent_items;
	int directed_items;

	region_address_remapper_core #(.NUM_REGIONS(NUM_SLOTS)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watch both handshakes; values seen here are the ones present at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_request(rar_pkg::op_t'(s_tuser), s_tdata[3:0], s_tdata[51:4],
					s_tdata[99:52], s_tdata[147:100]);
			if (m_tvalid && m_tready)
				sb.check_response(m_tdata, m_tuser);
		end
	end

	// receiver back-pressure: cycles through always ready, coin flip, every fifth, and rare
	int rx_cycle = 0;
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		case ((rx_cycle / 97) % 4)
			0:       m_tready <= 1'b1;
			1:       m_tready <= 1'($urandom_range(0, 1));
			2:       m_tready <= (rx_cycle % 5 == 0);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	function automatic logic [ADDR_W-1:0] rand_addr();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[ADDR_W-1:0];
	endfunction

	// random slot that currently holds a region, or -1 when the table is empty
	function automatic int pick_used_slot();
		int used_ids[$];
		for (int i = 0; i < NUM_SLOTS; i++)
			if (sb.region_used[i])
				used_ids.push_back(i);
		if (used_ids.size() == 0)
			return -1;
		return used_ids[$urandom_range(0, used_ids.size() - 1)];
	endfunction

	// present one item and hold it until the block takes it; valid stays high afterwards
	task automatic send_item(rar_pkg::op_t op, logic [ID_W-1:0] id, logic [ADDR_W-1:0] base,
			logic [ADDR_W-1:0] upper, logic [ADDR_W-1:0] lookup);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, lookup, upper, base, id};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_items++;
	endtask

	task automatic sender_gap(int cycles);
		if (cycles > 0) begin
			s_tvalid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// well-formed items mostly: inserts with small spans, sets matching the region span,
	// lookups in and around existing regions; the rest is noise
	task automatic send_random_item();
		rar_pkg::op_t      op;
		logic [ID_W-1:0]   id;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] upper;
		logic [ADDR_W-1:0] lookup;
		logic [63:0]       span;
		int                r;
		int                slot;
		r      = $urandom_range(0, 99);
		id     = ID_W'($urandom_range(0, NUM_SLOTS - 1));
		base   = rand_addr();
		upper  = rand_addr();
		lookup = rand_addr();
		slot   = pick_used_slot();
		if (r < 5)
			op = rar_pkg::OP_NONE;
		else if (r < 30)
			op = rar_pkg::OP_INSERT;
		else if (r < 52)
			op = rar_pkg::OP_SET;
		else
			op = rar_pkg::OP_TRANSLATE;
		case (op)
			rar_pkg::OP_INSERT: begin
				if (slot >= 0 && $urandom_range(0, 9) == 0)
					base = sb.region_lo[slot];   // duplicate base
				if ($urandom_range(0, 9) < 8)
					upper = base + ADDR_W'($urandom_range(0, 4095));
			end
			rar_pkg::OP_SET: begin
				if (slot >= 0 && $urandom_range(0, 99) < 85)
					id = ID_W'(slot);
				// span copied only from a slot that holds a region
				if (sb.region_used[id] && $urandom_range(0, 9) < 8)
					upper = base + (sb.region_hi[id] - sb.region_lo[id]);
			end
			rar_pkg::OP_TRANSLATE: begin
				if (slot >= 0 && $urandom_range(0, 99) < 85) begin
					span = {16'b0, ADDR_W'(sb.region_hi[slot] - sb.region_lo[slot])} + 64'd1;
					case ($urandom_range(0, 9))
						6:       lookup = sb.region_lo[slot];
						7:       lookup = sb.region_hi[slot];
						8:       lookup = sb.region_hi[slot] + 1'b1;
						9:       lookup = sb.region_lo[slot] - 1'b1;
						default: lookup = sb.region_lo[slot] + ADDR_W'({$urandom, $urandom} % span);
					endcase
				end
			end
			default: ;
		endcase
		send_item(op, id, base, upper, lookup);
	endtask

	initial begin
		logic [ADDR_W-1:0] ones;
		int                burst;
		ones = '1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, unused opcode, set on empty slot
		send_item(rar_pkg::OP_TRANSLATE, 4'd0, '0, '0, '0);
		send_item(rar_pkg::OP_NONE, 4'd15, ones, ones, ones);
		send_item(rar_pkg::OP_SET, 4'd0, 48'h5000, 48'h5fff, '0);
		// insert, then duplicate base into another slot and into the same slot
		send_item(rar_pkg::OP_INSERT, 4'd0, 48'h1000, 48'h1fff, '0);
		sender_gap(2);
		send_item(rar_pkg::OP_INSERT, 4'd1, 48'h1000, 48'h1800, '0);
		send_item(rar_pkg::OP_INSERT, 4'd0, 48'h1000, 48'h1fff, '0);
		// address equal to a region base before any translation
		send_item(rar_pkg::OP_TRANSLATE, 4'd0, '0, '0, 48'h1000);
		// size mismatch, then a translation whose rebased address wraps
		send_item(rar_pkg::OP_SET, 4'd0, 48'h5000, 48'h5ffe, '0);
		send_item(rar_pkg::OP_SET, 4'd0, 48'hffff_ffff_f800, 48'h0000_0000_07ff, '0);
		send_item(rar_pkg::OP_TRANSLATE, 4'd0, '0, '0, 48'h1000);
		send_item(rar_pkg::OP_TRANSLATE, 4'd0, '0, '0, 48'h1fff);
		sender_gap(1);
		send_item(rar_pkg::OP_TRANSLATE, 4'd0, '0, '0, 48'h2000);   // past the upper bound
		send_item(rar_pkg::OP_TRANSLATE, 4'd0, '0, '0, 48'h0fff);   // nothing at or below
		// region at the very top of the address space
		send_item(rar_pkg::OP_INSERT, 4'd15, ones, ones, '0);
		send_item(rar_pkg::OP_TRANSLATE, 4'd0, '0, '0, ones);
		send_item(rar_pkg::OP_SET, 4'd15, '0, '0, '0);
		send_item(rar_pkg::OP_TRANSLATE, 4'd0, '0, '0, ones);
		// upper below base: region exists but covers nothing
		send_item(rar_pkg::OP_INSERT, 4'd2, 48'h3000, 48'h2000, '0);
		send_item(rar_pkg::OP_TRANSLATE, 4'd0, '0, '0, 48'h3000);
		// reinsert into a used slot drops its translation
		send_item(rar_pkg::OP_INSERT, 4'd0, 48'h8000, 48'h8fff, '0);
		sender_gap(3);
		send_item(rar_pkg::OP_TRANSLATE, 4'd0, '0, '0, 48'h8000);
		// span that wraps around the address width
		send_item(rar_pkg::OP_INSERT, 4'd3, 48'h0010, 48'h0000, '0);
		send_item(rar_pkg::OP_SET, 4'd3, 48'h0005, 48'hffff_ffff_fff5, '0);
		send_item(rar_pkg::OP_TRANSLATE, 4'd0, '0, '0, 48'h1000);
		directed_items = sent_items;

		// random bursts with random gaps, some bursts back to back
		while (sent_items < directed_items + RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			repeat (burst)
				send_random_item();
			if ($urandom_range(0, 3) != 0)
				sender_gap($urandom_range(1, 6));
		end
		s_tvalid <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d items (%0d directed), %0d results checked, %0d rebased addresses",
			sent_items, directed_items, sb.checked, sb.hits);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#400_000;
		$display("timeout with %0d results still expected", sb.pending_results.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
